// ===== sv/beam_element_stiffness_accumulate_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the beam element stiffness accumulator
// Shared wrappers so that every checked module writes its properties alike.
// ----------------------------------------------------------------------------
`ifndef BEAM_ELEMENT_STIFFNESS_ACCUMULATE_DEFINES_SVH
`define BEAM_ELEMENT_STIFFNESS_ACCUMULATE_DEFINES_SVH

// Generic clocked assertion with a synchronous reset that disables it.
`define BESA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The same on the block's own clock and reset.
`define BESA_CHECK(label, prop, msg) \
   `BESA_ASSERT(label, clock, reset, prop, msg)

`endif

// ===== sv/besa_pkg.sv =====
// ----------------------------------------------------------------------------
// besa_pkg
// Shared widths, register codes and controller-to-datapath bundles.
// ----------------------------------------------------------------------------
package besa_pkg;

   localparam int IDX_W       = 3;   // basis, row and column index
   localparam int CNT_W       = 4;   // basis_count register
   localparam int DATA_W      = 32;  // Q16.16 operands
   localparam int FRAC_W      = 16;
   localparam int STIFF_W     = 31;  // unsigned stiffness registers
   localparam int ACC_W       = 64;  // Q32.32 accumulator entries
   // Accumulator address sized for the largest supported element (8 x 8).
   localparam int ACC_ADDR_W  = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 72;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASIS_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEND_STIFFNESS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHEAR_RIGIDITY  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STIFFNESS_RATIO = 2'd3;

   localparam logic [CNT_W-1:0]   BASIS_COUNT_RESET = 4'd4;
   localparam logic [STIFF_W-1:0] ONE_Q16           = 31'd65536;

   typedef struct packed {
      logic                  accept;      // request taken this cycle
      logic                  row_rd;      // read the basis row store
      logic [IDX_W-1:0]      row_addr;
      logic                  row_cap;     // hold row i terms for the pass
      logic                  pair_issue;  // start one (i, j) update
      logic                  emit_rd;     // read one accumulator entry out
      logic [ACC_ADDR_W-1:0] acc_addr;
      logic                  emit_load;   // move read entry into output register
      logic                  emit_clear;  // matrix fully emitted, clear it
      logic [IDX_W-1:0]      out_row;
      logic [IDX_W-1:0]      out_col;
      logic                  out_last;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

// ===== sv/besa_ctrl.sv =====
// ----------------------------------------------------------------------------
// besa_ctrl
// Sequencer for row storage, the per-point update pass and matrix emission.
// ----------------------------------------------------------------------------
`include "beam_element_stiffness_accumulate_defines.svh"

module besa_ctrl #(
   parameter int MAX_BASIS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [besa_pkg::IDX_W-1:0]   req_index,
   input  logic                         req_last_point,
   input  logic [$clog2(MAX_BASIS)-1:0] n_m1,
   input  besa_pkg::status_type         status,
   output besa_pkg::cmd_type            cmd
);
   import besa_pkg::*;

   localparam int IW = $clog2(MAX_BASIS);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ROW     = 3'd1;
   localparam logic [2:0] ST_ROWCAP  = 3'd2;
   localparam logic [2:0] ST_PAIR    = 3'd3;
   localparam logic [2:0] ST_DRAIN   = 3'd4;
   localparam logic [2:0] ST_EMIT_RD = 3'd5;
   localparam logic [2:0] ST_EMIT_LD = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic          last_pt_ff, last_pt_in;
   logic          accept;
   logic          i_last;
   logic          j_last;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      last_pt_in = last_pt_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      i_last     = (i_ff == n_m1);
      j_last     = (j_ff == n_m1);

      cmd.accept   = accept;
      cmd.row_addr = IDX_W'(j_ff);
      cmd.acc_addr = ACC_ADDR_W'(32'(i_ff) * MAX_BASIS + 32'(j_ff));
      cmd.out_row  = IDX_W'(i_ff);
      cmd.out_col  = IDX_W'(j_ff);
      cmd.out_last = i_last && j_last;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_index == IDX_W'(n_m1))) begin
               last_pt_in = req_last_point;
               i_in       = '0;
               j_in       = '0;
               state_in   = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_rd   = 1'b1;
            cmd.row_addr = IDX_W'(i_ff);
            state_in     = ST_ROWCAP;
         end
         ST_ROWCAP: begin
            cmd.row_cap = 1'b1;
            j_in        = '0;
            state_in    = ST_PAIR;
         end
         ST_PAIR: begin
            cmd.row_rd     = 1'b1;
            cmd.pair_issue = 1'b1;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ROW;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               i_in     = '0;
               j_in     = '0;
               state_in = last_pt_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (i_last && j_last) begin
                  cmd.emit_clear = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         i_ff       <= '0;
         j_ff       <= '0;
         last_pt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         last_pt_ff <= last_pt_in;
      end
   end

   // Emission must only start once every update of the pass has landed.
   `BESA_CHECK(a_emit_after_drain, (state_ff == ST_EMIT_RD) |-> !status.pipe_busy, "emit while busy")
   // Pair counters stay inside the active element during a pass.
   `BESA_CHECK(a_pair_in_range, (state_ff == ST_PAIR) |-> (i_ff <= n_m1) && (j_ff <= n_m1), "pair out of range")
   // A finished pass leaves the pair pipeline idle before new requests are taken.
   `BESA_CHECK(a_idle_quiet, (state_ff == ST_IDLE) && $past(state_ff == ST_DRAIN) |-> !status.pipe_busy, "idle while busy")

endmodule

// ===== sv/besa_dpath.sv =====
// ----------------------------------------------------------------------------
// besa_dpath
// Row store, four-stage update pipeline, accumulator memory and output register.
// ----------------------------------------------------------------------------
`include "beam_element_stiffness_accumulate_defines.svh"

module besa_dpath #(
   parameter int MAX_BASIS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  besa_pkg::cmd_type                    cmd,
   output besa_pkg::status_type                 status,
   input  logic [besa_pkg::IDX_W-1:0]           req_index,
   input  logic signed [besa_pkg::DATA_W-1:0]   req_second,
   input  logic signed [besa_pkg::DATA_W-1:0]   req_third,
   input  logic signed [besa_pkg::DATA_W-1:0]   req_weight,
   input  logic [besa_pkg::STIFF_W-1:0]         bend_stiffness,
   input  logic [besa_pkg::STIFF_W-1:0]         shear_rigidity,
   input  logic [besa_pkg::STIFF_W-1:0]         stiffness_ratio,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [besa_pkg::IDX_W-1:0]           rsp_row,
   output logic [besa_pkg::IDX_W-1:0]           rsp_col,
   output logic signed [besa_pkg::ACC_W-1:0]    rsp_value,
   output logic                                 rsp_last
);
   import besa_pkg::*;

   localparam int IW        = $clog2(MAX_BASIS);
   localparam int ACC_DEPTH = MAX_BASIS * MAX_BASIS;
   localparam int AW        = $clog2(ACC_DEPTH);
   localparam int HI        = FRAC_W + DATA_W - 1;

   // Row store: shear term in the upper half, bending term in the lower.
   logic [2*DATA_W-1:0]       row_mem [MAX_BASIS];
   logic [2*DATA_W-1:0]       row_rd_ff;
   logic signed [ACC_W-1:0]   shear_prod;
   logic [DATA_W-1:0]         shear_term;
   logic                      store_ok;

   logic signed [DATA_W-1:0]  bi_bend_ff, bi_shear_ff, dv_ff;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]             addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic signed [ACC_W-1:0]   pb, ps, tbp, tsp;
   logic signed [DATA_W-1:0]  q_bend_ff, q_shear_ff, q_bend_in, q_shear_in;
   logic signed [DATA_W-1:0]  tb_ff, ts_ff, tb_in, ts_in;
   logic signed [DATA_W-1:0]  s_sum;
   logic signed [ACC_W-1:0]   m_ff, m_in;

   logic [ACC_W-1:0]          acc_mem [ACC_DEPTH];
   logic [ACC_W-1:0]          acc_rd_ff;
   logic                      hit_ff;
   logic                      acc_rd_en;
   logic [AW-1:0]             acc_rd_addr;
   logic [ACC_DEPTH-1:0]      acc_valid_ff;
   logic [ACC_W-1:0]          acc_old;
   logic [ACC_W-1:0]          acc_sum;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic [ACC_W-1:0]          rsp_value_ff;
   logic                      rsp_last_ff;

   // Shear term of the incoming function, negated after the Q16.16 product.
   always_comb begin
      shear_prod = $signed({1'b0, stiffness_ratio}) * req_third;
      shear_term = DATA_W'(0) - shear_prod[HI:FRAC_W];
      store_ok   = (32'(req_index) < MAX_BASIS);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store_ok) begin
         row_mem[req_index[IW-1:0]] <= {shear_term, req_second};
      end
      if (cmd.row_rd) begin
         row_rd_ff <= row_mem[cmd.row_addr[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dv_ff <= req_weight;
      end
      if (cmd.row_cap) begin
         bi_bend_ff  <= row_rd_ff[DATA_W-1:0];
         bi_shear_ff <= row_rd_ff[2*DATA_W-1:DATA_W];
      end
   end

   // Stage 1: row products; stage 2: stiffness scaling; stage 3: weight product.
   always_comb begin
      pb         = bi_bend_ff * $signed(row_rd_ff[DATA_W-1:0]);
      ps         = bi_shear_ff * $signed(row_rd_ff[2*DATA_W-1:DATA_W]);
      q_bend_in  = pb[HI:FRAC_W];
      q_shear_in = ps[HI:FRAC_W];
      tbp        = $signed({1'b0, bend_stiffness}) * q_bend_ff;
      tsp        = $signed({1'b0, shear_rigidity}) * q_shear_ff;
      tb_in      = tbp[HI:FRAC_W];
      ts_in      = tsp[HI:FRAC_W];
      s_sum      = tb_ff + ts_ff;
      m_in       = dv_ff * s_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.pair_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff   <= cmd.acc_addr[AW-1:0];
      addr2_ff   <= addr1_ff;
      addr3_ff   <= addr2_ff;
      addr4_ff   <= addr3_ff;
      q_bend_ff  <= q_bend_in;
      q_shear_ff <= q_shear_in;
      tb_ff      <= tb_in;
      ts_ff      <= ts_in;
      m_ff       <= m_in;
   end

   // Accumulator: one read port shared by the update pass and emission.
   always_comb begin
      acc_rd_en   = v3_ff || cmd.emit_rd;
      acc_rd_addr = cmd.emit_rd ? cmd.acc_addr[AW-1:0] : addr3_ff;
      acc_old     = hit_ff ? acc_rd_ff : '0;
      acc_sum     = acc_old + m_ff;
   end

   always_ff @(posedge clock) begin
      if (acc_rd_en) begin
         acc_rd_ff <= acc_mem[acc_rd_addr];
         hit_ff    <= acc_valid_ff[acc_rd_addr];
      end
      if (v4_ff) begin
         acc_mem[addr4_ff] <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit_clear) begin
         acc_valid_ff <= '0;
      end else if (v4_ff) begin
         acc_valid_ff[addr4_ff] <= 1'b1;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_row_ff   <= cmd.out_row;
         rsp_col_ff   <= cmd.out_col;
         rsp_value_ff <= acc_old;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_col          = rsp_col_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // The accumulator write and an emission read never share a cycle.
   `BESA_CHECK(a_no_emit_during_update, v4_ff |-> !cmd.emit_rd, "emit read during update")
   // An update issue never competes with emission for the read port.
   `BESA_CHECK(a_issue_not_emit, cmd.pair_issue |-> !cmd.emit_rd && !cmd.emit_load, "port clash")
   // A loaded entry is only placed into a free output register.
   `BESA_CHECK(a_load_free, cmd.emit_load |-> status.out_free, "output overwritten")

endmodule

// ===== sv/beam_element_stiffness_accumulate.sv =====
// ----------------------------------------------------------------------------
// beam_element_stiffness_accumulate
// Element stiffness matrix accumulation by Gauss quadrature (top level).
// ----------------------------------------------------------------------------
// Usage: each request on req_* describes one basis function at one quadrature
// point. The block stores its bending term and its shear term. The request
// whose basis_index equals basis_count-1 closes the point: the block adds
// dV*(Kb*b0i*b0j + Ks*b1i*b1j) into all n-by-n accumulator entries. When that
// request also has req_tlast (last quadrature point) set, the whole matrix is
// sent on rsp_* in row-major order, rsp_tlast marks its final entry, and the
// accumulator is cleared.
// Sequence: a request that does not close a point only stores its terms. A
// closing request runs one pass of the shared update pipeline: per row, a
// read and capture of row i, then one (i, j) issue per column, set by the
// single read port of the row store, then a drain of its four stages. Each
// entry is emitted by an accumulator read, then an output register load.
// A stalled receiver (rsp_tready low) holds the output register and pauses
// emission; the last entry can wait there while new requests are accepted.
// Reset (synchronous) returns the controller to idle, empties the pipeline,
// marks every accumulator entry as zero and loads the register defaults:
// basis_count 4 and unit stiffnesses and ratio. No clearing pass is needed.
// ----------------------------------------------------------------------------
module beam_element_stiffness_accumulate #(
   parameter int MAX_BASIS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // basis_index[2:0], second_deriv[34:3], third_deriv[66:35],
   // volume_weight[98:67], zero fill above
   input  logic [besa_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tlast,      // last_point
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // row[2:0], col[5:3], entry_value[69:6], zero fill above
   output logic [besa_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,      // last
   input  logic                                  csr_we,
   input  logic [besa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [besa_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import besa_pkg::*;

   localparam int IW = $clog2(MAX_BASIS);

   // Configuration registers.
   logic [CNT_W-1:0]   basis_count_ff, basis_count_in;
   logic [STIFF_W-1:0] bend_ff, bend_in;
   logic [STIFF_W-1:0] shear_ff, shear_in;
   logic [STIFF_W-1:0] ratio_ff, ratio_in;
   logic [IW-1:0]      n_m1;

   cmd_type            cmd;
   status_type         status;

   logic [IDX_W-1:0]   rsp_row;
   logic [IDX_W-1:0]   rsp_col;
   logic [ACC_W-1:0]   rsp_value;

   always_comb begin
      basis_count_in = basis_count_ff;
      bend_in        = bend_ff;
      shear_in       = shear_ff;
      ratio_in       = ratio_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASIS_COUNT:     basis_count_in = csr_wdata[CNT_W-1:0];
            CSR_BEND_STIFFNESS:  bend_in        = csr_wdata[STIFF_W-1:0];
            CSR_SHEAR_RIGIDITY:  shear_in       = csr_wdata[STIFF_W-1:0];
            CSR_STIFFNESS_RATIO: ratio_in       = csr_wdata[STIFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_count_ff <= BASIS_COUNT_RESET;
         bend_ff        <= ONE_Q16;
         shear_ff       <= ONE_Q16;
         ratio_ff       <= ONE_Q16;
      end else begin
         basis_count_ff <= basis_count_in;
         bend_ff        <= bend_in;
         shear_ff       <= shear_in;
         ratio_ff       <= ratio_in;
      end
   end

   // Active count minus one: a count of zero acts as one, and counts above
   // the supported maximum act as the maximum.
   always_comb begin
      if (basis_count_ff == '0) begin
         n_m1 = '0;
      end else if (32'(basis_count_ff) > MAX_BASIS) begin
         n_m1 = IW'(MAX_BASIS - 1);
      end else begin
         n_m1 = IW'(basis_count_ff - 1'b1);
      end
   end

   besa_ctrl #(
      .MAX_BASIS (MAX_BASIS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_index      (req_tdata[2:0]),
      .req_last_point (req_tlast),
      .n_m1           (n_m1),
      .status         (status),
      .cmd            (cmd)
   );

   besa_dpath #(
      .MAX_BASIS (MAX_BASIS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_index       (req_tdata[2:0]),
      .req_second      (req_tdata[34:3]),
      .req_third       (req_tdata[66:35]),
      .req_weight      (req_tdata[98:67]),
      .bend_stiffness  (bend_ff),
      .shear_rigidity  (shear_ff),
      .stiffness_ratio (ratio_ff),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_row         (rsp_row),
      .rsp_col         (rsp_col),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_value, rsp_col, rsp_row};

endmodule

// ===== test/beam_element_stiffness_accumulate_checker.sv =====
// ----------------------------------------------------------------------------
// Stiffness accumulator scoreboard
// Watches the request, response and CSR ports of the accumulator. It keeps
// its own copy of the registers, the row stores and the matrix. It predicts
// every stiffness entry and compares each response against the oldest one.
// ----------------------------------------------------------------------------
module beam_stiffness_checker #(
   parameter int MAX_BASIS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [besa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [besa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [besa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [besa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending_count,
   output int                                entries_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import besa_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [ACC_W-1:0] value;
      logic             last;
   } stiffness_entry_type;

   stiffness_entry_type expected_entries[$];

   logic [CNT_W-1:0]   basis_count;
   logic [STIFF_W-1:0] bend_k;
   logic [STIFF_W-1:0] shear_k;
   logic [STIFF_W-1:0] ratio;
   logic [DATA_W-1:0]  bend_row [MAX_BASIS];
   logic [DATA_W-1:0]  shear_row [MAX_BASIS];
   logic [ACC_W-1:0]   stiffness_acc [MAX_BASIS*MAX_BASIS];
   int                 fails;
   int                 checked;

   function automatic logic signed [63:0] widen(input logic [DATA_W-1:0] v);
      return {{32{v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [63:0] widen_u(input logic [STIFF_W-1:0] v);
      return {33'd0, v};
   endfunction

   // Q16.16 product: exact in 64 bits, arithmetic shift by 16, keep 32 bits.
   function automatic logic [DATA_W-1:0] fix_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] prod;
      prod = a * b;
      return prod[47:16];
   endfunction

   function automatic int active_count();
      if (basis_count == 0) return 1;
      if (basis_count > MAX_BASIS) return MAX_BASIS;
      return int'(basis_count);
   endfunction

   // Stores the item's terms; a closing item adds the point into the matrix
   // and, on the element's last point, queues the whole matrix and clears it.
   task automatic accumulate_point(input logic [REQ_TDATA_W-1:0] data,
                                   input logic last_point);
      logic [IDX_W-1:0]    idx;
      logic [DATA_W-1:0]   dv;
      logic [DATA_W-1:0]   tb;
      logic [DATA_W-1:0]   ts;
      logic [DATA_W-1:0]   sum;
      stiffness_entry_type ent;
      int                  n;
      idx = data[2:0];
      dv  = data[98:67];
      n   = active_count();
      if (idx < MAX_BASIS) begin
         bend_row[idx]  = data[34:3];
         shear_row[idx] = -fix_mul(widen_u(ratio), widen(data[66:35]));
      end
      if (int'(idx) != n - 1) return;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            tb  = fix_mul(widen_u(bend_k),
                          widen(fix_mul(widen(bend_row[i]), widen(bend_row[j]))));
            ts  = fix_mul(widen_u(shear_k),
                          widen(fix_mul(widen(shear_row[i]), widen(shear_row[j]))));
            sum = tb + ts;
            stiffness_acc[i*MAX_BASIS+j] += widen(dv) * widen(sum);
         end
      end
      if (!last_point) return;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            ent.row   = i[IDX_W-1:0];
            ent.col   = j[IDX_W-1:0];
            ent.value = stiffness_acc[i*MAX_BASIS+j];
            ent.last  = (i == n - 1) && (j == n - 1);
            expected_entries.push_back(ent);
         end
      end
      foreach (stiffness_acc[k]) stiffness_acc[k] = '0;
   endtask

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endfunction

   task automatic check_entry();
      stiffness_entry_type want;
      if (expected_entries.size() == 0) begin
         $error("entry with no prediction: row %0d col %0d value %0h",
                rsp_tdata[2:0], rsp_tdata[5:3], rsp_tdata[69:6]);
         fails++;
         return;
      end
      want = expected_entries.pop_front();
      compare_field("row", 64'(want.row), 64'(rsp_tdata[2:0]));
      compare_field("col", 64'(want.col), 64'(rsp_tdata[5:3]));
      compare_field("entry_value", want.value, rsp_tdata[69:6]);
      compare_field("last", 64'(want.last), 64'(rsp_tlast));
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         basis_count = BASIS_COUNT_RESET;
         bend_k      = ONE_Q16;
         shear_k     = ONE_Q16;
         ratio       = ONE_Q16;
         foreach (bend_row[k]) begin
            bend_row[k]  = '0;
            shear_row[k] = '0;
         end
         foreach (stiffness_acc[k]) stiffness_acc[k] = '0;
         expected_entries.delete();
         fails   = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASIS_COUNT:     basis_count = csr_wdata[CNT_W-1:0];
               CSR_BEND_STIFFNESS:  bend_k      = csr_wdata;
               CSR_SHEAR_RIGIDITY:  shear_k     = csr_wdata;
               CSR_STIFFNESS_RATIO: ratio       = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accumulate_point(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_entry();
      end
      fail_count      <= fails;
      pending_count   <= expected_entries.size();
      entries_checked <= checked;
   end

endmodule

// ===== test/beam_element_stiffness_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// Stiffness accumulator regression bench
// Drives quadrature requests and CSR settings into the accumulator, stalls
// the response side, and leaves prediction and comparison to the scoreboard.
// ----------------------------------------------------------------------------
module beam_element_stiffness_accumulate_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import besa_pkg::*;

   localparam int MAX_BASIS = 8;
   // This margin covers one closing request with n = 8 in the update pipeline,
   // plus a little before any CSR write or verdict.
   localparam int SETTLE_CYCLES = 120;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int pending_count;
   int entries_checked;

   // Stimulus-side bookkeeping. The bench tracks the effective basis count
   // and which row slots have been written, so that a closing request never
   // makes the block read a row slot that holds nothing yet.
   int       active_n;
   bit [7:0] rows_written;
   int       requests_sent;
   int       random_sent;
   int       settings_used;
   int       burst_left;
   int       stall_left;
   bit       gaps_on;
   bit       stalls_on;

   always #10 clock = ~clock;

   beam_element_stiffness_accumulate #(.MAX_BASIS(MAX_BASIS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   beam_stiffness_checker #(.MAX_BASIS(MAX_BASIS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .entries_checked (entries_checked)
   );

   // The receiver either takes every entry or runs its own stall pattern:
   // mostly ready, with occasional stalls of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left <= int'($urandom_range(1, 12));
      end
   end

   // Sends one request. Requests go out in bursts; between bursts the valid
   // drops for a random gap unless gaps are switched off for the phase.
   // Valid stays high from one request to the next inside a burst.
   task automatic send_item(input logic [2:0] idx, input logic [31:0] second,
                            input logic [31:0] third, input logic [31:0] weight,
                            input logic last_point);
      int gap;
      // A closing request reads rows 0 to n-1; fall back to the first unwritten
      // slot instead, which then only stores its terms.
      if (int'(idx) == active_n - 1) begin
         for (int k = 0; k < int'(idx); k++) begin
            if (!rows_written[k]) begin
               idx = k[2:0];
               break;
            end
         end
      end
      if (burst_left == 0) begin
         if (gaps_on) begin
            gap = int'($urandom_range(1, 6));
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 10));
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, weight, third, second, idx};
      req_tlast  <= last_point;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      rows_written[idx] = 1'b1;
      requests_sent++;
   endtask

   // Holds the sender until every predicted entry has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Registers are written only with the block idle: every entry received,
   // then enough cycles for a pass that emits nothing to finish.
   task automatic write_config(input logic [3:0] count, input logic [30:0] bend,
                               input logic [30:0] shear, input logic [30:0] kratio);
      logic [26:0] fill;
      fill = 27'($urandom());
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASIS_COUNT;
      csr_wdata <= {fill, count};
      @(posedge clock);
      csr_index <= CSR_BEND_STIFFNESS;
      csr_wdata <= bend;
      @(posedge clock);
      csr_index <= CSR_SHEAR_RIGIDITY;
      csr_wdata <= shear;
      @(posedge clock);
      csr_index <= CSR_STIFFNESS_RATIO;
      csr_wdata <= kratio;
      @(posedge clock);
      csr_we <= 1'b0;
      active_n = (count == 0) ? 1 : (count > MAX_BASIS) ? MAX_BASIS : int'(count);
      settings_used++;
   endtask

   // Q16.16 operand: mostly modest values that keep sums meaningful, with
   // the extremes and full-range patterns mixed in.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         6, 7:    return $urandom();
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   function automatic logic [30:0] pick_stiffness();
      case ($urandom_range(0, 5))
         0:       return 31'd0;
         1:       return 31'h7FFF_FFFF;
         2:       return ONE_Q16;
         3:       return 31'($urandom());
         default: return 31'($urandom_range(0, 32'h0004_0000));
      endcase
   endfunction

   // One element: several quadrature points with indices 0 to n-1 in order,
   // the element's last point flagged on its closing request. Now and then a
   // stray request slips in: a slot outside the element, a rewrite, or a
   // premature close. A broken element never sends its last point, so the
   // next phase continues it under new settings.
   task automatic run_element(input int points, input bit broken);
      logic [31:0] weight;
      logic        flag;
      for (int p = 0; p < points; p++) begin
         weight = pick_operand();
         for (int k = 0; k < active_n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                         pick_operand(), 1'($urandom_range(0, 1)));
               random_sent++;
            end
            if (k == active_n - 1) flag = (p == points - 1) && !broken;
            else flag = 1'($urandom_range(0, 1));
            send_item(k[2:0], pick_operand(), pick_operand(), weight, flag);
            random_sent++;
         end
      end
   endtask

   initial begin
      logic [3:0] count;
      logic [30:0] shear;
      active_n      = int'(BASIS_COUNT_RESET);
      rows_written  = '0;
      requests_sent = 0;
      random_sent   = 0;
      settings_used = 0;
      burst_left    = 0;
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Slots outside a four-function element are stored
      // first with extreme operands; the first point also carries a stray
      // last-point flag on a request that does not close it.
      send_item(3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_item(3'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_item(3'd6, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_item(3'd7, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1'b0);
      send_item(3'd0, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF, 1'b1);
      send_item(3'd1, 32'hFFFE_0000, 32'h0003_0000, 32'h0000_0000, 1'b0);
      send_item(3'd2, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_item(3'd3, 32'h0002_8000, 32'h0000_0001, 32'h0001_0000, 1'b0);
      send_item(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_item(3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_item(3'd2, 32'h0004_0000, 32'hFFFC_0000, 32'h0000_0000, 1'b0);
      send_item(3'd3, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 1'b1);

      // A count of zero behaves as one; largest stiffness and ratio, least
      // shear stiffness.
      write_config(4'd0, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
      send_item(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_item(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

      // A count above the maximum behaves as eight: the full 8 x 8 matrix.
      write_config(4'd15, 31'd0, 31'h7FFF_FFFF, 31'd0);
      stalls_on = 1'b0;
      for (int k = 0; k < MAX_BASIS; k++)
         send_item(k[2:0], pick_operand(), pick_operand(), 32'h0000_8000,
                   k == MAX_BASIS - 1);

      // Count changed inside an element: a 2 x 2 point, then a 3 x 3 point
      // that closes the element and emits the third row and column too.
      stalls_on = 1'b1;
      write_config(4'd2, ONE_Q16, ONE_Q16, ONE_Q16);
      send_item(3'd0, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);
      send_item(3'd1, 32'hFFFF_0000, 32'h0000_4000, 32'h0001_0000, 1'b0);
      write_config(4'd3, ONE_Q16, ONE_Q16, ONE_Q16);
      send_item(3'd2, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_C000, 1'b1);

      // Random part: each phase picks new settings and idle behavior, then
      // runs a few elements. Small elements dominate; eight appears at times.
      while (requests_sent < 120) begin
         case ($urandom_range(0, 9))
            0:       count = 4'd0;
            1:       count = 4'($urandom_range(9, 15));
            2:       count = 4'd8;
            default: count = 4'($urandom_range(1, 4));
         endcase
         shear = pick_stiffness();
         if (shear == 0) shear = 31'd1;
         write_config(count, pick_stiffness(), shear, pick_stiffness());
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            run_element(int'($urandom_range(1, 3)), $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d requests (%0d random) under %0d register settings.",
               requests_sent, random_sent, settings_used);
      $display("Stiffness entries compared: %0d.", entries_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run,
   // even with every element at 8 x 8.
   initial begin
      #20_000_000;
      $display("Timeout with %0d entries still outstanding.", pending_count);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
